/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a property on every rising clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

/* hw/rtl/msp_pkg.sv */
// ----------------------------------------------------------------------------
// MSP request frame parser package
// Frame constants and sequencer states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package msp_pkg;

  // Header bytes of a request frame.
  localparam logic [7:0] SYNC_DOLLAR = 8'h24;
  localparam logic [7:0] SYNC_M      = 8'h4D;
  localparam logic [7:0] SYNC_REQ    = 8'h3C;

  // Frame positions, counted as bytes held after the current one is stored.
  localparam int unsigned POS_DOLLAR   = 1;
  localparam int unsigned POS_M        = 2;
  localparam int unsigned POS_REQ      = 3;
  localparam int unsigned POS_SIZE     = 4;
  localparam int unsigned POS_CMD      = 5;
  localparam int unsigned HDR_AND_TAIL = 6;

  // Store address of the first payload byte.
  localparam int unsigned PAYLOAD_OFS = 5;

  // Width of the frame length compare (size byte plus header and tail).
  localparam int unsigned CMP_W = 9;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SEND
  } msp_state_e;

endpackage

/* hw/rtl/msp_request_frame_parser_unit.sv */
// ----------------------------------------------------------------------------
// MSP request frame parser
// Recognizes '$' 'M' '<' size cmd payload checksum frames and emits payloads.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o / rx_byte_i) takes one received
//   serial byte per beat. Every byte is written to the frame store at the
//   current frame position and, from the size byte on, folded into the
//   running XOR checksum by the one shared XOR unit; a byte that breaks
//   the header is dropped. When the last byte of a frame with a zero
//   checksum arrives, the block drops in_ready_o and a small sequencer
//   walks the payload in the store: a read step reads a byte from the
//   store port, then one beat goes out on the result channel. A frame of
//   N payload bytes gives N beats, with last_o on the final beat, before
//   input is taken again. An empty payload gives one beat with has_data_o
//   low and last_o high. Input bytes that do not end a good frame are
//   taken without a stall.
//   A stall on out_ready_i holds the result beat and keeps input blocked.
//   Frames whose size byte is BUF_BYTES-6 or more never complete: the frame
//   is dropped when the store fills. Bad frames are dropped silently.
//   Reset clears frame position, checksum and sequencer; the store itself
//   is never cleared, since only bytes of the current frame are read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module msp_request_frame_parser_unit #(
  parameter int unsigned BUF_BYTES = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Received bytes
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  // Result beats
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] command_o,
  output logic [5:0] payload_size_o,
  output logic       has_data_o,
  output logic [7:0] data_byte_o,
  output logic [5:0] byte_index_o,
  output logic       last_o
);

  import msp_pkg::*;

  localparam int unsigned POS_W = $clog2(BUF_BYTES);

  msp_state_e state_q, state_d;

  logic [POS_W-1:0] pos_q, pos_d;     // bytes held of the current frame
  logic [7:0]       chk_q, chk_d;     // running XOR from the size byte on
  logic [7:0]       size_q, size_d;
  logic [7:0]       cmd_q, cmd_d;
  logic [POS_W-1:0] idx_q, idx_d;     // payload index being emitted
  logic             has_q, has_d;
  logic             last_q, last_d;
  logic [7:0]       rd_data_q;

  logic [7:0]       frame_mem [BUF_BYTES];

  logic             in_beat;
  logic             out_beat;
  logic [POS_W:0]   pos_inc;
  logic [POS_W:0]   pos_new;
  logic             hdr_bad;
  logic             wrap;
  logic [7:0]       chk_new;
  logic             frame_done;
  logic [POS_W:0]   rd_sum;
  logic [POS_W-1:0] rd_addr;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_SEND);
  assign in_beat     = in_valid_i && in_ready_o;
  assign out_beat    = out_valid_o && out_ready_i;

  // Position after the incoming byte, with header and buffer-full checks.
  assign pos_inc = {1'b0, pos_q} + (POS_W+1)'(1);
  assign hdr_bad = ((pos_inc == (POS_W+1)'(POS_DOLLAR)) && (rx_byte_i != SYNC_DOLLAR)) ||
                   ((pos_inc == (POS_W+1)'(POS_M))      && (rx_byte_i != SYNC_M))      ||
                   ((pos_inc == (POS_W+1)'(POS_REQ))    && (rx_byte_i != SYNC_REQ));
  assign wrap    = (pos_inc >= (POS_W+1)'(BUF_BYTES));
  assign pos_new = (hdr_bad || wrap) ? '0 : pos_inc;

  // Shared XOR unit: restart on the size byte, fold in every later byte.
  assign chk_new = (pos_new == (POS_W+1)'(POS_SIZE)) ? rx_byte_i : (chk_q ^ rx_byte_i);

  // Frame ends when the position reaches size + header + checksum.
  assign frame_done = (pos_new >= (POS_W+1)'(HDR_AND_TAIL)) &&
                      (CMP_W'(pos_new) == (CMP_W'(size_q) + CMP_W'(HDR_AND_TAIL)));

  // Store address of the payload byte being emitted.
  assign rd_sum  = {1'b0, idx_q} + (POS_W+1)'(PAYLOAD_OFS);
  assign rd_addr = rd_sum[POS_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pos_q   <= '0;
      chk_q   <= '0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      chk_q   <= chk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    size_q <= size_d;
    cmd_q  <= cmd_d;
    idx_q  <= idx_d;
    has_q  <= has_d;
    last_q <= last_d;
  end

  // Frame store: write each accepted byte, read one payload byte per read step.
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      frame_mem[pos_q] <= rx_byte_i;
    end
    if (state_q == ST_READ) begin
      rd_data_q <= frame_mem[rd_addr];
    end
  end

  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    chk_d   = chk_q;
    size_d  = size_q;
    cmd_d   = cmd_q;
    idx_d   = idx_q;
    has_d   = has_q;
    last_d  = last_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          if (pos_new >= (POS_W+1)'(POS_SIZE)) begin
            chk_d = chk_new;
          end
          if (pos_new == (POS_W+1)'(POS_SIZE)) begin
            size_d = rx_byte_i;
          end
          if (pos_new == (POS_W+1)'(POS_CMD)) begin
            cmd_d = rx_byte_i;
          end
          if (frame_done) begin
            pos_d = '0;
            idx_d = '0;
            if (chk_new == 8'h00) begin
              if (size_q == 8'h00) begin
                // Empty payload: one beat without data.
                has_d   = 1'b0;
                last_d  = 1'b1;
                state_d = ST_SEND;
              end else begin
                has_d   = 1'b1;
                state_d = ST_READ;
              end
            end
          end else begin
            pos_d = pos_new[POS_W-1:0];
          end
        end
      end
      ST_READ: begin
        last_d  = ((CMP_W'(idx_q) + CMP_W'(1)) == CMP_W'(size_q));
        state_d = ST_SEND;
      end
      ST_SEND: begin
        if (out_beat) begin
          if (last_q) begin
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_q + POS_W'(1);
            state_d = ST_READ;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign command_o      = cmd_q;
  assign payload_size_o = size_q[5:0];
  assign has_data_o     = has_q;
  assign data_byte_o    = has_q ? rd_data_q : 8'h00;
  assign byte_index_o   = 6'(idx_q);
  assign last_o         = last_q;

  `ASSERT_NEVER(a_no_overlap, clk_i, rst_ni, in_ready_o && out_valid_o, "input taken while result pending")
  `ASSERT_PROP(a_read_then_send, clk_i, rst_ni, (state_q == ST_READ) |=> out_valid_o, "read step not followed by a result beat")
  `ASSERT_PROP(a_last_ends_frame, clk_i, rst_ni, (out_beat && last_o) |=> in_ready_o, "input not resumed after last beat")
  `ASSERT_PROP(a_empty_is_last, clk_i, rst_ni, (out_valid_o && !has_data_o) |-> (last_o && (byte_index_o == 6'd0) && (data_byte_o == 8'h00)), "empty payload beat malformed")

endmodule
